>>> rtl/core/snm_pkg.sv
// Shared constants, types and a helper function for the short name match block.
package snm_pkg;

  localparam int unsigned CHARS    = 12;
  localparam int unsigned NAME_LEN = 8;
  localparam int unsigned EXT_LEN  = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Character positions run 0 to 12; 12 means "not found" or "full length".
  typedef logic [3:0] pos_t;

  localparam pos_t POS_NONE = 4'd12;

  typedef struct packed {
    logic [CHARS-1:0][7:0]    up;
    pos_t                     len;
    pos_t                     dot;
    logic [NAME_LEN-1:0][7:0] stored_name;
    logic [EXT_LEN-1:0][7:0]  stored_ext;
  } scan_t;

  typedef struct packed {
    logic [NAME_LEN-1:0][7:0] conv_name;
    logic [EXT_LEN-1:0][7:0]  conv_ext;
    logic [NAME_LEN-1:0][7:0] stored_name;
    logic [EXT_LEN-1:0][7:0]  stored_ext;
  } conv_t;

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
      return ch - CASE_OFS;
    end
    return ch;
  endfunction

endpackage

>>> rtl/core/snm_ifs.sv
// Valid/ready channel interfaces for the input and result items.
interface snm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] stored_name;
  logic [23:0] stored_ext;
  logic [63:0] user_head;
  logic [31:0] user_tail;

  modport source (output valid, stored_name, stored_ext, user_head, user_tail, input ready);
  modport sink (input valid, stored_name, stored_ext, user_head, user_tail, output ready);
endinterface

interface snm_out_if;
  logic        valid;
  logic        ready;
  logic        is_match;
  logic [63:0] conv_name;
  logic [23:0] conv_ext;

  modport source (output valid, is_match, conv_name, conv_ext, input ready);
  modport sink (input valid, is_match, conv_name, conv_ext, output ready);
endinterface

>>> rtl/core/snm_scan.sv
// First stage: upper-cases every character and finds the name end and first dot.
module snm_scan
  import snm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] stored_name_i,
  input  logic [23:0] stored_ext_i,
  input  logic [63:0] user_head_i,
  input  logic [31:0] user_tail_i,
  output logic        valid_o,
  input  logic        ready_i,
  output scan_t       data_o
);

  logic                  valid_r;
  scan_t                 data_r;
  scan_t                 data_nxt;
  logic [CHARS-1:0][7:0] chars;

  assign chars = {user_tail_i, user_head_i};

  // Scanning from the top down leaves the lowest matching position.
  always_comb begin
    data_nxt.len         = POS_NONE;
    data_nxt.dot         = POS_NONE;
    data_nxt.stored_name = stored_name_i;
    data_nxt.stored_ext  = stored_ext_i;
    for (int i = CHARS - 1; i >= 0; i--) begin
      data_nxt.up[i] = to_upper(chars[i]);
      if (chars[i] == CH_NUL) begin
        data_nxt.len = pos_t'(i);
      end
      if (chars[i] == CH_DOT) begin
        data_nxt.dot = pos_t'(i);
      end
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> rtl/core/snm_pack.sv
// Second stage: builds the space-padded name and extension from the scan result.
module snm_pack
  import snm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  output logic  ready_o,
  input  scan_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output conv_t data_o
);

  logic       valid_r;
  conv_t      data_r;
  conv_t      data_nxt;
  logic       has_dot;
  pos_t       name_end;
  logic [4:0] ext_pos [EXT_LEN];

  // A dot at or past the end of the name does not split it.
  assign has_dot = data_i.dot < data_i.len;

  always_comb begin
    name_end = has_dot ? data_i.dot : data_i.len;
    if (name_end > pos_t'(NAME_LEN)) begin
      name_end = pos_t'(NAME_LEN);
    end
  end

  always_comb begin
    data_nxt.stored_name = data_i.stored_name;
    data_nxt.stored_ext  = data_i.stored_ext;
    for (int i = 0; i < NAME_LEN; i++) begin
      data_nxt.conv_name[i] = (pos_t'(i) < name_end) ? data_i.up[i] : CH_SPACE;
    end
    for (int e = 0; e < EXT_LEN; e++) begin
      ext_pos[e]           = {1'b0, data_i.dot} + 5'd1 + 5'(e);
      data_nxt.conv_ext[e] = CH_SPACE;
      if (has_dot && ext_pos[e] < {1'b0, data_i.len}) begin
        for (int j = 0; j < CHARS; j++) begin
          if (ext_pos[e] == 5'(j)) begin
            data_nxt.conv_ext[e] = data_i.up[j];
          end
        end
      end
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> rtl/core/snm_cmp.sv
// Third stage: compares against the stored name and holds the result item.
module snm_cmp
  import snm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  output logic        ready_o,
  input  conv_t       data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        is_match_o,
  output logic [63:0] conv_name_o,
  output logic [23:0] conv_ext_o
);

  logic        valid_r;
  logic        is_match_r;
  logic        is_match_nxt;
  logic [63:0] conv_name_r;
  logic [23:0] conv_ext_r;

  assign is_match_nxt = (data_i.conv_name == data_i.stored_name) &&
                        (data_i.conv_ext == data_i.stored_ext);

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      is_match_r  <= is_match_nxt;
      conv_name_r <= data_i.conv_name;
      conv_ext_r  <= data_i.conv_ext;
    end
  end

  assign valid_o     = valid_r;
  assign is_match_o  = is_match_r;
  assign conv_name_o = conv_name_r;
  assign conv_ext_o  = conv_ext_r;

endmodule

>>> rtl/core/short_name_match_top.sv
// An accepted item is registered in the scan, pack and compare stages in turn before its result is offered.
// Throughput: one item per cycle while the output is not stalled; each of the three stages holds one item.
// A stalled output stage only blocks the stages behind it once they are full.
// Reset (synchronous, active low) empties all three stages; the block holds no other state.
// Top level of the short name match block.
module short_name_match_top
  import snm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  snm_in_if.sink       in_ch,
  snm_out_if.source    out_ch
);

  logic  scan_valid;
  logic  scan_ready;
  scan_t scan_data;
  logic  pack_valid;
  logic  pack_ready;
  conv_t pack_data;

  snm_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (in_ch.valid),
    .ready_o       (in_ch.ready),
    .stored_name_i (in_ch.stored_name),
    .stored_ext_i  (in_ch.stored_ext),
    .user_head_i   (in_ch.user_head),
    .user_tail_i   (in_ch.user_tail),
    .valid_o       (scan_valid),
    .ready_i       (scan_ready),
    .data_o        (scan_data)
  );

  snm_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (scan_valid),
    .ready_o (scan_ready),
    .data_i  (scan_data),
    .valid_o (pack_valid),
    .ready_i (pack_ready),
    .data_o  (pack_data)
  );

  snm_cmp u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (pack_valid),
    .ready_o     (pack_ready),
    .data_i      (pack_data),
    .valid_o     (out_ch.valid),
    .ready_i     (out_ch.ready),
    .is_match_o  (out_ch.is_match),
    .conv_name_o (out_ch.conv_name),
    .conv_ext_o  (out_ch.conv_ext)
  );

endmodule

>>> rtl/core/snm_checker.sv
// Port-level checker for the short name match block and its bind statement.
module snm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result waiting on a stalled sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present right after reset");

  // With the sink taking items, no stage can be blocked.
  a_no_block: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input blocked while output is ready");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready && rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) &&
    $past(out_ready, 2) && $past(out_ready, 1) |-> out_valid)
    else $error("item did not reach the output in three cycles");

endmodule

bind short_name_match_top snm_checker u_snm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
